FILE: rtl/button_click_mode_controller_defines.svh
// ----------------------------------------------------------------------------
// button click mode controller assertion macros
// shared concurrent checks, clocked on clk and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_MODE_CONTROLLER_DEFINES_SVH
`define BUTTON_CLICK_MODE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define BCMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bcmc_pkg.sv
// ----------------------------------------------------------------------------
// bcmc_pkg
// types and constants of the button click mode controller
// ----------------------------------------------------------------------------
package bcmc_pkg;

    localparam int TIME_W   = 48;
    localparam int SPAN_W   = 24;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_CONTROL,
        KIND_RAIN,
        KIND_POLL
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_CROSS,
        MODE_RAIN,
        MODE_AP
    } mode_t;

    typedef enum logic [1:0] {
        CLICK_NONE,
        CLICK_SHORT,
        CLICK_LONG
    } click_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_DEBOUNCE,
        REG_LONG_CLICK
    } reg_idx_t;

    typedef struct packed {
        kind_t               kind;
        logic                pin_level;
        logic [TIME_W-1:0]   time_us;
    } item_t;

    typedef struct packed {
        mode_t mode;
        logic  attention;
        logic  leds_off;
        logic  enter_access_point;
        logic  leave_access_point;
    } result_t;

    typedef struct packed {
        logic [SPAN_W-1:0] dbc_span;
        logic [SPAN_W-1:0] long_click_span;
    } cfg_t;

endpackage

FILE: rtl/bcmc_core.sv
// ----------------------------------------------------------------------------
// bcmc_core
// button state, pending clicks and operating mode; next result is combinational
// ----------------------------------------------------------------------------
module bcmc_core
    import bcmc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic                ctrl_level_reg, ctrl_level_next;
    logic [TIME_W-1:0]   ctrl_last_reg, ctrl_last_next;
    logic                rain_level_reg, rain_level_next;
    logic [TIME_W-1:0]   rain_last_reg, rain_last_next;
    click_t              ctrl_pending_reg, ctrl_pending_next;
    logic                rain_pending_reg, rain_pending_next;
    mode_t               mode_reg, mode_next;
    logic                attention_reg, attention_next;

    logic [TIME_W:0]     now_ext;
    logic [TIME_W:0]     ctrl_dbc_sum;
    logic [TIME_W:0]     ctrl_long_sum;
    logic [TIME_W:0]     rain_dbc_sum;
    logic                ctrl_past_dbc;
    logic                ctrl_past_long;
    logic                rain_past_dbc;
    logic                is_poll;
    logic                short_in_ap;

    // sums are one bit wider so that last + span never wraps
    assign now_ext       = {1'b0, item.time_us};
    assign ctrl_dbc_sum  = {1'b0, ctrl_last_reg}
                         + {{(TIME_W+1-SPAN_W){1'b0}}, cfg.dbc_span};
    assign ctrl_long_sum = {1'b0, ctrl_last_reg}
                         + {{(TIME_W+1-SPAN_W){1'b0}}, cfg.long_click_span};
    assign rain_dbc_sum  = {1'b0, rain_last_reg}
                         + {{(TIME_W+1-SPAN_W){1'b0}}, cfg.dbc_span};
    assign ctrl_past_dbc  = now_ext > ctrl_dbc_sum;
    assign ctrl_past_long = now_ext > ctrl_long_sum;
    assign rain_past_dbc  = now_ext > rain_dbc_sum;

    assign is_poll     = item.kind == KIND_POLL;
    assign short_in_ap = ctrl_pending_reg == CLICK_SHORT && mode_reg == MODE_AP;

    // button edges and pending clicks
    always_comb
    begin
        ctrl_level_next   = ctrl_level_reg;
        ctrl_last_next    = ctrl_last_reg;
        rain_level_next   = rain_level_reg;
        rain_last_next    = rain_last_reg;
        ctrl_pending_next = ctrl_pending_reg;
        rain_pending_next = rain_pending_reg;
        attention_next    = attention_reg;
        unique case (item.kind)
            KIND_CONTROL:
            begin
                if (item.pin_level && ctrl_past_dbc)
                begin
                    ctrl_pending_next = ctrl_past_long ? CLICK_LONG : CLICK_SHORT;
                end
                ctrl_level_next = item.pin_level;
                ctrl_last_next  = item.time_us;
            end
            KIND_RAIN:
            begin
                if (item.pin_level && !rain_level_reg && rain_past_dbc)
                begin
                    rain_pending_next = 1'b1;
                end
                rain_level_next = item.pin_level;
                rain_last_next  = item.time_us;
            end
            KIND_POLL:
            begin
                attention_next    = !ctrl_level_reg && (ctrl_last_reg != '0)
                                  && ctrl_past_long;
                ctrl_pending_next = CLICK_NONE;
                // a short click leaving access point keeps the rain click waiting
                if (!short_in_ap)
                begin
                    rain_pending_next = 1'b0;
                end
            end
            default:
            begin
                ctrl_pending_next = ctrl_pending_reg;
            end
        endcase
    end

    // operating mode, next state
    always_comb
    begin
        mode_next = mode_reg;
        if (is_poll)
        begin
            unique case (ctrl_pending_reg)
                CLICK_SHORT:
                begin
                    if (mode_reg == MODE_AP)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else
                    begin
                        mode_next = (mode_reg == MODE_CROSS) ? MODE_NORMAL : MODE_CROSS;
                    end
                end
                CLICK_LONG:
                begin
                    mode_next = MODE_AP;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
            if (rain_pending_reg && !short_in_ap)
            begin
                if (mode_next == MODE_NORMAL)
                begin
                    mode_next = MODE_RAIN;
                end
                else if (mode_next == MODE_RAIN)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
        end
    end

    // result of this item
    always_comb
    begin
        result.mode               = mode_next;
        result.attention          = attention_next;
        result.leds_off           = is_poll && (ctrl_pending_reg == CLICK_SHORT
                                             || ctrl_pending_reg == CLICK_LONG);
        result.enter_access_point = is_poll && ctrl_pending_reg == CLICK_LONG;
        result.leave_access_point = is_poll && short_in_ap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_level_reg   <= 1'b0;
            ctrl_last_reg    <= '0;
            rain_level_reg   <= 1'b0;
            rain_last_reg    <= '0;
            ctrl_pending_reg <= CLICK_NONE;
            rain_pending_reg <= 1'b0;
            mode_reg         <= MODE_NORMAL;
            attention_reg    <= 1'b0;
        end
        else if (take)
        begin
            ctrl_level_reg   <= ctrl_level_next;
            ctrl_last_reg    <= ctrl_last_next;
            rain_level_reg   <= rain_level_next;
            rain_last_reg    <= rain_last_next;
            ctrl_pending_reg <= ctrl_pending_next;
            rain_pending_reg <= rain_pending_next;
            mode_reg         <= mode_next;
            attention_reg    <= attention_next;
        end
    end

endmodule

FILE: rtl/button_click_mode_controller.sv
// ----------------------------------------------------------------------------
// button_click_mode_controller
// debounced short/long press detector driving the operating mode
//
//   channel   signals                          direction
//   item      item_valid, item_ready, item     in  (kind, pin_level, time_us)
//   result    result_valid, result_ready, result  out (mode, attention, pulses)
//   config    psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// one item per cycle unless the result stalls; each result is valid in the cycle after its transfer
// the result register decouples the sides: a new item is taken whenever the
// result register is empty or its result is taken in the same cycle
// a stalled result holds the block's state; no item is lost or repeated
// reset clears button state, pending clicks and mode, and loads the config defaults
// ----------------------------------------------------------------------------
`include "button_click_mode_controller_defines.svh"

module button_click_mode_controller
    import bcmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;
    logic     take;
    logic     result_valid_reg, result_valid_next;
    result_t  result_reg;
    result_t  core_result;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_DEBOUNCE:
                prdata = {{(APB_DATA_W-SPAN_W){1'b0}}, cfg_reg.dbc_span};
            REG_LONG_CLICK:
                prdata = {{(APB_DATA_W-SPAN_W){1'b0}}, cfg_reg.long_click_span};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dbc_span        <= SPAN_W'(50000);
            cfg_reg.long_click_span <= SPAN_W'(1500000);
        end
        else if (cfg_write)
        begin
            if (reg_idx == REG_DEBOUNCE)
            begin
                cfg_reg.dbc_span <= pwdata[SPAN_W-1:0];
            end
            else
            begin
                cfg_reg.long_click_span <= pwdata[SPAN_W-1:0];
            end
        end
    end

    assign item_ready = !result_valid_reg || result_ready;
    assign take       = item_valid && item_ready;

    bcmc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (take)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `BCMC_ASSERT_NOW(a_enter_is_ap, result_valid && result.enter_access_point, result.mode == MODE_AP, "enter pulse without access point mode")
    `BCMC_ASSERT_NOW(a_leave_is_normal, result_valid && result.leave_access_point, result.mode == MODE_NORMAL, "leave pulse without normal mode")
    `BCMC_ASSERT_NOW(a_pulse_leds, result_valid && (result.enter_access_point || result.leave_access_point), result.leds_off && !(result.enter_access_point && result.leave_access_point), "access point pulse without single leds pulse")
    `BCMC_ASSERT_NEXT(a_drain, result_valid && result_ready && !take, !result_valid, "result register not emptied after transfer")

endmodule
